// File: hdl/json_string_unescape_utf8_defines.svh
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define JSU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define JSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
    localparam logic [3:0] ERR_TRUNC     = 4'd2;
    localparam logic [3:0] ERR_CTRL      = 4'd3;
    localparam logic [3:0] ERR_BAD_ESC   = 4'd4;
    localparam logic [3:0] ERR_BAD_HEX   = 4'd5;
    localparam logic [3:0] ERR_LONE_HIGH = 4'd6;
    localparam logic [3:0] ERR_BAD_LOW   = 4'd7;
    localparam logic [3:0] ERR_LONE_LOW  = 4'd8;

    // Packet queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] char_byte;
        logic       text_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic [3:0] error_code;
        logic       last_of_run;
    } t_out;

    // All results caused by one input byte
    typedef struct packed {
        logic [2:0]      num;
        logic [1:0]      kind;
        logic [3:0]      err;
        logic [3:0][7:0] bytes;
    } t_pkt;

    typedef struct packed {
        logic push;
        t_pkt pkt;
    } t_push;

endpackage

`default_nettype wire

// File: hdl/jsu_fifo.sv
`default_nettype none

module jsu_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jsu_pkg::t_push i_push,
    input  wire logic          i_pop,
    output jsu_pkg::t_pkt      o_head,
    output logic               o_full,
    output logic               o_empty
);

    jsu_pkg::t_pkt                  r_mem [jsu_pkg::FIFO_DEPTH];
    logic [jsu_pkg::FIFO_AW-1:0]    r_wr;
    logic [jsu_pkg::FIFO_AW-1:0]    r_rd;
    logic [jsu_pkg::FIFO_AW:0]      r_count;
    logic                           w_do_push;
    logic                           w_do_pop;

    assign o_full    = (r_count == (jsu_pkg::FIFO_AW+1)'(jsu_pkg::FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rd];
    assign w_do_push = i_push.push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Store packet
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_push.pkt;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/jsu_front.sv
`default_nettype none

module jsu_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire jsu_pkg::t_in   i_data,
    output jsu_pkg::t_push      o_push
);

    typedef enum logic [2:0] {
        S_IDLE, S_STR, S_ESC, S_HEX_A, S_PAIR_BS, S_PAIR_U, S_HEX_B
    } t_mode;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    t_mode        r_mode, n_mode;
    logic [15:0]  r_hex, n_hex;
    logic [1:0]   r_cnt, n_cnt;
    logic [9:0]   r_high, n_high;
    logic         r_bad, n_bad;

    jsu_pkg::t_pkt w_pkt;
    logic [3:0]    w_digit;
    logic          w_digit_bad;
    logic [15:0]   w_acc;
    logic [20:0]   w_pair_cp;
    logic [7:0]    w_c;
    logic          w_end;

    function automatic jsu_pkg::t_pkt utf8_enc(input logic [20:0] cp);
        jsu_pkg::t_pkt p;
        p       = '0;
        p.kind  = jsu_pkg::KIND_BYTE;
        p.err   = jsu_pkg::ERR_NONE;
        if (cp <= 21'h7F) begin
            p.num      = 3'd1;
            p.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            p.num      = 3'd2;
            p.bytes[0] = {3'b110, cp[10:6]};
            p.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            p.num      = 3'd3;
            p.bytes[0] = {4'b1110, cp[15:12]};
            p.bytes[1] = {2'b10, cp[11:6]};
            p.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            p.num      = 3'd4;
            p.bytes[0] = {5'b11110, cp[20:18]};
            p.bytes[1] = {2'b10, cp[17:12]};
            p.bytes[2] = {2'b10, cp[11:6]};
            p.bytes[3] = {2'b10, cp[5:0]};
        end
        return p;
    endfunction

    function automatic jsu_pkg::t_pkt one_result(input logic [1:0] kind,
                                                 input logic [3:0] err,
                                                 input logic [7:0] b);
        jsu_pkg::t_pkt p;
        p          = '0;
        p.num      = 3'd1;
        p.kind     = kind;
        p.err      = err;
        p.bytes[0] = b;
        return p;
    endfunction

    assign w_c   = i_data.char_byte;
    assign w_end = i_data.text_end;

    // Decode one hex digit
    always_comb begin
        w_digit_bad = 1'b0;
        w_digit     = 4'd0;
        if (w_c >= 8'h30 && w_c <= 8'h39) begin
            w_digit = w_c[3:0];
        end else if ((w_c >= 8'h61 && w_c <= 8'h66) || (w_c >= 8'h41 && w_c <= 8'h46)) begin
            w_digit = w_c[3:0] + 4'd9;
        end else begin
            w_digit_bad = 1'b1;
        end
    end

    assign w_acc     = {r_hex[11:0], w_digit};
    assign w_pair_cp = 21'h10000 + {1'b0, r_high, w_acc[9:0]};

    // Classify the byte and work out next state
    always_comb begin
        n_mode = r_mode;
        n_hex  = r_hex;
        n_cnt  = r_cnt;
        n_high = r_high;
        n_bad  = r_bad;
        w_pkt  = '0;
        case (r_mode)
            S_STR: begin
                if (w_end) begin
                    w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_TRUNC, 8'd0);
                end else if (w_c == CH_QUOTE) begin
                    w_pkt = one_result(jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE, 8'd0);
                end else if (w_c < 8'h20) begin
                    w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_CTRL, 8'd0);
                end else if (w_c == CH_BSL) begin
                    n_mode = S_ESC;
                end else begin
                    w_pkt = one_result(jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, w_c);
                end
            end
            S_ESC: begin
                n_mode = S_STR;
                if (w_end) begin
                    w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_TRUNC, 8'd0);
                end else begin
                    case (w_c)
                        CH_QUOTE, CH_BSL, CH_SLASH:
                            w_pkt = one_result(jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, w_c);
                        CH_B: w_pkt = one_result(jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h08);
                        CH_F: w_pkt = one_result(jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h0C);
                        CH_N: w_pkt = one_result(jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h0A);
                        CH_R: w_pkt = one_result(jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h0D);
                        CH_T: w_pkt = one_result(jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE, 8'h09);
                        CH_U: begin
                            n_mode = S_HEX_A;
                            n_hex  = '0;
                            n_cnt  = '0;
                            n_bad  = 1'b0;
                        end
                        default:
                            w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_BAD_ESC, 8'd0);
                    endcase
                end
            end
            S_HEX_A, S_HEX_B: begin
                if (w_end) begin
                    w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_TRUNC, 8'd0);
                end else if (r_cnt != 2'd3) begin
                    n_hex = w_acc;
                    n_cnt = r_cnt + 2'd1;
                    n_bad = r_bad | w_digit_bad;
                end else begin
                    n_hex = w_acc;
                    n_cnt = '0;
                    if (r_bad || w_digit_bad) begin
                        w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_BAD_HEX, 8'd0);
                    end else if (r_mode == S_HEX_A) begin
                        if (w_acc[15:10] == 6'b110110) begin
                            n_high = w_acc[9:0];
                            n_mode = S_PAIR_BS;
                        end else if (w_acc[15:10] == 6'b110111) begin
                            w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_LONE_LOW, 8'd0);
                        end else begin
                            n_mode = S_STR;
                            w_pkt  = utf8_enc({5'd0, w_acc});
                        end
                    end else begin
                        if (w_acc[15:10] != 6'b110111) begin
                            w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_BAD_LOW, 8'd0);
                        end else begin
                            n_high = '0;
                            n_mode = S_STR;
                            w_pkt  = utf8_enc(w_pair_cp);
                        end
                    end
                end
            end
            S_PAIR_BS: begin
                if (w_end || w_c != CH_BSL) begin
                    w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_LONE_HIGH, 8'd0);
                end else begin
                    n_mode = S_PAIR_U;
                end
            end
            S_PAIR_U: begin
                if (w_end || w_c != CH_U) begin
                    w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_LONE_HIGH, 8'd0);
                end else begin
                    n_mode = S_HEX_B;
                    n_hex  = '0;
                    n_cnt  = '0;
                    n_bad  = 1'b0;
                end
            end
            default: begin
                if (w_end) begin
                    w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_TRUNC, 8'd0);
                end else if (w_c != CH_QUOTE) begin
                    w_pkt = one_result(jsu_pkg::KIND_ERR, jsu_pkg::ERR_NO_QUOTE, 8'd0);
                end else begin
                    n_mode = S_STR;
                    n_hex  = '0;
                    n_cnt  = '0;
                    n_high = '0;
                    n_bad  = 1'b0;
                end
            end
        endcase
        // Close and every error drop back to idle
        if (w_pkt.num != 3'd0 && w_pkt.kind != jsu_pkg::KIND_BYTE) begin
            n_mode = S_IDLE;
            n_hex  = '0;
            n_cnt  = '0;
            n_high = '0;
            n_bad  = 1'b0;
        end
    end

    assign o_push.push = i_accept && (w_pkt.num != 3'd0);
    assign o_push.pkt  = w_pkt;

    // Hold decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE;
            r_hex  <= '0;
            r_cnt  <= '0;
            r_high <= '0;
            r_bad  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_cnt  <= n_cnt;
            r_high <= n_high;
            r_bad  <= n_bad;
        end
    end

endmodule

`default_nettype wire

// File: hdl/jsu_back.sv
`default_nettype none

module jsu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jsu_pkg::t_pkt i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output jsu_pkg::t_out      o_data
);

    logic          r_valid;
    jsu_pkg::t_out r_data;
    logic [1:0]    r_idx;
    logic          w_load;
    logic          w_last;
    jsu_pkg::t_out w_res;

    assign w_load = !r_valid || !i_stall;
    assign w_last = ((3'(r_idx) + 3'd1) == i_head.num);
    assign o_pop  = w_load && !i_empty && w_last;

    // Pick the current result of the head packet
    always_comb begin
        w_res.out_byte    = (i_head.kind == jsu_pkg::KIND_BYTE) ? i_head.bytes[r_idx] : 8'd0;
        w_res.result_kind = i_head.kind;
        w_res.error_code  = i_head.err;
        w_res.last_of_run = w_last;
    end

    // Advance through the packet and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_empty) begin
            r_data <= w_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: hdl/json_string_unescape_utf8.sv
// Channel | Direction | Handshake                      | Beat
// in      | input     | i_in_valid / o_in_stall        | t_in: char_byte, text_end
// out     | output    | o_out_valid / i_out_stall      | t_out: out_byte, result_kind,
//         |           |                                |   error_code, last_of_run
//
// One input beat is taken per cycle unless stalled; it is decoded in that cycle and its
// 0..4 results go into a four-packet queue. The back end sends one result per cycle
// unless stalled, so an escape that yields N UTF-8 bytes gives N result beats; each
// result is registered in the queue and then in the output register. o_in_stall rises
// only when the packet queue is full. i_rst_n is synchronous and active low; it returns
// the decoder to idle and empties the queue and the output register.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire jsu_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output jsu_pkg::t_out      o_out_data
);

    jsu_pkg::t_push w_push;
    jsu_pkg::t_pkt  w_head;
    logic           w_full;
    logic           w_empty;
    logic           w_pop;
    logic           w_accept;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_data   (i_in_data),
        .o_push   (w_push)
    );

    jsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: hdl/jsu_checker.sv
`default_nettype none
`include "json_string_unescape_utf8_defines.svh"

module jsu_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire jsu_pkg::t_in  i_in_data,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire jsu_pkg::t_out o_out_data
);

    logic w_unused;
    assign w_unused = i_in_valid ^ o_in_stall ^ (^i_in_data);

    // A stalled result beat stays valid and unchanged
    `JSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "out valid dropped while stalled")
    `JSU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data), "out beat changed while stalled")

    // Close and error results end a run and carry no byte
    `JSU_ASSERT_NOW(a_end_kind, i_clk, i_rst_n, o_out_valid && o_out_data.result_kind != jsu_pkg::KIND_BYTE, o_out_data.last_of_run && o_out_data.out_byte == 8'd0 && (o_out_data.result_kind == jsu_pkg::KIND_CLOSE || o_out_data.result_kind == jsu_pkg::KIND_ERR), "close or error beat malformed")

    // Error code is set exactly on error results
    `JSU_ASSERT_NOW(a_err_code, i_clk, i_rst_n, o_out_valid, (o_out_data.result_kind == jsu_pkg::KIND_ERR) == (o_out_data.error_code != jsu_pkg::ERR_NONE), "error code does not match kind")

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

`default_nettype wire
